/* hw/rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and character constants for the base64url stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Special characters of the alphabet
  localparam logic [7:0] CHAR_PAD    = 8'h3D;  // '='
  localparam logic [7:0] CHAR_DASH   = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_USCORE = 8'h5F;  // '_'
  localparam logic [7:0] CHAR_UPPER_A = 8'h41; // 'A'
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A; // 'Z'
  localparam logic [7:0] CHAR_LOWER_A = 8'h61; // 'a'
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A; // 'z'
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30; // '0'
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39; // '9'

  // Sextet values
  localparam logic [5:0] SEXTET_LOWER  = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT  = 6'd52;
  localparam logic [5:0] SEXTET_DASH   = 6'd62;
  localparam logic [5:0] SEXTET_USCORE = 6'd63;

  // Group positions
  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;
  localparam logic [1:0] PHASE_FOURTH = 2'd3;

  // Classified character
  typedef struct packed {
    logic       is_pad;
    logic       is_data;
    logic [5:0] sextet;
  } b64d_char_t;

  // One result beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       string_done;
    logic       decode_error;
  } b64d_result_t;

endpackage

/* hw/rtl/b64d_classify.sv */
// ----------------------------------------------------------------------------
// b64d_classify
// Maps a raw character to its sextet value and pad / data flags.
// ----------------------------------------------------------------------------
module b64d_classify (
  input  logic [7:0]          char_code,
  output b64d_pkg::b64d_char_t cls
);
  import b64d_pkg::*;

  always_comb begin
    cls.is_pad  = (char_code == CHAR_PAD);
    cls.is_data = 1'b1;
    cls.sextet  = '0;
    if (char_code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      cls.sextet = 6'(char_code - CHAR_UPPER_A);
    end else if (char_code inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      cls.sextet = 6'(char_code - CHAR_LOWER_A) + SEXTET_LOWER;
    end else if (char_code inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
      cls.sextet = 6'(char_code - CHAR_DIGIT_0) + SEXTET_DIGIT;
    end else if (char_code == CHAR_DASH) begin
      cls.sextet = SEXTET_DASH;
    end else if (char_code == CHAR_USCORE) begin
      cls.sextet = SEXTET_USCORE;
    end else begin
      cls.is_data = 1'b0;
    end
  end

endmodule

/* hw/rtl/b64d_core.sv */
// ----------------------------------------------------------------------------
// b64d_core
// Group state and byte assembly; state advances on each step.
// ----------------------------------------------------------------------------
module b64d_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  b64d_pkg::b64d_char_t   cls,
  input  logic                   final_char,
  output b64d_pkg::b64d_result_t res
);
  import b64d_pkg::*;

  logic [1:0] group_phase, group_phase_next;
  logic [5:0] carry_bits, carry_bits_next;
  logic       padding_seen, padding_seen_next;
  logic       error_flag, error_flag_next;

  always_comb begin
    group_phase_next  = group_phase;
    carry_bits_next   = carry_bits;
    padding_seen_next = padding_seen;
    error_flag_next   = error_flag;
    res.data_byte     = '0;
    res.byte_valid    = 1'b0;

    if (!error_flag) begin
      if (cls.is_pad) begin
        padding_seen_next = 1'b1;
      end else if (!cls.is_data || padding_seen) begin
        error_flag_next = 1'b1;
      end else begin
        case (group_phase)
          PHASE_FIRST: begin
            carry_bits_next  = cls.sextet;
            group_phase_next = PHASE_SECOND;
          end
          PHASE_SECOND: begin
            res.data_byte    = {carry_bits, cls.sextet[5:4]};
            res.byte_valid   = 1'b1;
            carry_bits_next  = {2'b00, cls.sextet[3:0]};
            group_phase_next = PHASE_THIRD;
          end
          PHASE_THIRD: begin
            res.data_byte    = {carry_bits[3:0], cls.sextet[5:2]};
            res.byte_valid   = 1'b1;
            carry_bits_next  = {4'b0000, cls.sextet[1:0]};
            group_phase_next = PHASE_FOURTH;
          end
          default: begin
            res.data_byte    = {carry_bits[1:0], cls.sextet};
            res.byte_valid   = 1'b1;
            carry_bits_next  = '0;
            group_phase_next = PHASE_FIRST;
          end
        endcase
      end
    end

    // a lone data char in the last group is a length error
    res.string_done  = final_char;
    res.decode_error = final_char &&
                       (error_flag_next || group_phase_next == PHASE_SECOND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase  <= PHASE_FIRST;
      carry_bits   <= '0;
      padding_seen <= 1'b0;
      error_flag   <= 1'b0;
    end else if (step) begin
      if (final_char) begin
        group_phase  <= PHASE_FIRST;
        carry_bits   <= '0;
        padding_seen <= 1'b0;
        error_flag   <= 1'b0;
      end else begin
        group_phase  <= group_phase_next;
        carry_bits   <= carry_bits_next;
        padding_seen <= padding_seen_next;
        error_flag   <= error_flag_next;
      end
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && final_char |=> group_phase == PHASE_FIRST && carry_bits == '0 &&
                           !padding_seen && !error_flag)
    else $error("state not cleared after final char");

  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    res.byte_valid |-> cls.is_data && !error_flag && !padding_seen)
    else $error("byte emitted on pad, error or foreign char");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    step && !final_char && error_flag |=> error_flag)
    else $error("error flag dropped mid-string");

endmodule

/* hw/rtl/base64url_stream_decoder_top.sv */
// ----------------------------------------------------------------------------
// base64url_stream_decoder_top
// Streaming base64url decoder: one character in, one result beat out.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | char_code[7:0], final_char
//   out     | out_valid / out_ready| data_byte[7:0], byte_valid,
//           |                      | string_done, decode_error
//
// One character per cycle sustained while the output is not stalled; each
// character passes the input register, then the result register.
// Group state advances when a character moves from the input register into
// the result register, so back-to-back characters see the updated state.
// Synchronous active-high reset empties both registers and clears the group
// state; no other initialization is needed.
// A stalled output holds the result register; the input register still takes
// one more beat, then in_ready drops until the output drains.
//
module base64url_stream_decoder_top (
  input  logic       clk,
  input  logic       rst,
  // character input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       final_char,
  // result output
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       string_done,
  output logic       decode_error
);
  import b64d_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_final;

  logic         s1_advance;
  b64d_char_t   cls;
  b64d_result_t res;

  // stage 1 moves on when the result register is empty or draining
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char  <= char_code;
      s1_final <= final_char;
    end
  end

  b64d_classify u_classify (
    .char_code (s1_char),
    .cls       (cls)
  );

  b64d_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_advance),
    .cls        (cls),
    .final_char (s1_final),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      data_byte    <= res.data_byte;
      byte_valid   <= res.byte_valid;
      string_done  <= res.string_done;
      decode_error <= res.decode_error;
    end
  end

  a_err_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && decode_error |-> string_done)
    else $error("decode_error without string_done");

  a_no_stray_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> data_byte == '0)
    else $error("nonzero data_byte on beat without byte");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |=> out_valid)
    else $error("held character did not reach result register");

endmodule

/* verif/b64_decode_checker.sv */
// ----------------------------------------------------------------------------
// b64_decode_checker
// Watches both channels of the base64url stream decoder. It decodes every
// accepted character in its own model and compares each result beat, field
// by field, against the oldest decoded result still waiting.
// ----------------------------------------------------------------------------
module b64_decode_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       final_char,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] data_byte,
  input  logic       byte_valid,
  input  logic       string_done,
  input  logic       decode_error,
  output int         fail_count,
  output int         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  // decoder state of the model
  logic [1:0]   phase;
  logic [5:0]   carry;
  logic         pad_seen;
  logic         err_seen;

  b64d_result_t decoded_q[$];
  int           err_total;

  // bit 6 set: not an alphabet character
  function automatic logic [6:0] sextet_value(input logic [7:0] ch);
    logic [6:0] v;
    v = 7'h40;
    if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
      v = {1'b0, 6'(ch - CHAR_UPPER_A)};
    end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      v = {1'b0, 6'(ch - CHAR_LOWER_A) + SEXTET_LOWER};
    end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
      v = {1'b0, 6'(ch - CHAR_DIGIT_0) + SEXTET_DIGIT};
    end else if (ch == CHAR_DASH) begin
      v = {1'b0, SEXTET_DASH};
    end else if (ch == CHAR_USCORE) begin
      v = {1'b0, SEXTET_USCORE};
    end
    return v;
  endfunction

  function automatic void clear_state();
    phase    = PHASE_FIRST;
    carry    = '0;
    pad_seen = 1'b0;
    err_seen = 1'b0;
  endfunction

  function automatic b64d_result_t decode_char(input logic [7:0] ch, input logic last);
    b64d_result_t r;
    logic [6:0]   sv;
    r  = '0;
    sv = sextet_value(ch);
    if (!err_seen) begin
      if (ch == CHAR_PAD) begin
        pad_seen = 1'b1;
      end else if (sv[6] || pad_seen) begin
        err_seen = 1'b1;
      end else begin
        r.byte_valid = 1'b1;
        case (phase)
          PHASE_FIRST: begin
            r.byte_valid = 1'b0;
            carry        = sv[5:0];
            phase        = PHASE_SECOND;
          end
          PHASE_SECOND: begin
            r.data_byte = {carry[5:0], sv[5:4]};
            carry       = {2'b00, sv[3:0]};
            phase       = PHASE_THIRD;
          end
          PHASE_THIRD: begin
            r.data_byte = {carry[3:0], sv[5:2]};
            carry       = {4'b0000, sv[1:0]};
            phase       = PHASE_FOURTH;
          end
          default: begin
            r.data_byte = {carry[1:0], sv[5:0]};
            carry       = '0;
            phase       = PHASE_FIRST;
          end
        endcase
      end
    end
    if (last) begin
      // a lone character in the last group cannot make a byte
      r.string_done  = 1'b1;
      r.decode_error = err_seen || (phase == PHASE_SECOND);
      clear_state();
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      err_total++;
    end
  endfunction

  always @(posedge clk) begin
    b64d_result_t want;
    if (rst) begin
      clear_state();
      decoded_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("result beat with nothing pending: data_byte %0h", data_byte);
          err_total++;
        end else begin
          want = decoded_q.pop_front();
          check_field("data_byte", want.data_byte, data_byte);
          check_field("byte_valid", {7'b0, want.byte_valid}, {7'b0, byte_valid});
          check_field("string_done", {7'b0, want.string_done}, {7'b0, string_done});
          check_field("decode_error", {7'b0, want.decode_error},
                      {7'b0, decode_error});
        end
      end
      if (in_valid && in_ready)
        decoded_q.push_back(decode_char(char_code, final_char));
    end
    fail_count    <= err_total;
    pending_count <= decoded_q.size();
  end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives strings of characters into the base64url stream decoder, with
// random sender gaps and receiver stalls, and gives the verdict from the
// failure count of the checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
  localparam int RANDOM_CHARS   = 450;
  localparam int DRAIN_CYCLES   = 8;     // extra margin after the checker queue empties

  typedef logic [7:0] char_q_t[$];

  logic       clk = 1'b0;
  logic       rst = 1'b1;

  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] char_code  = '0;
  logic       final_char = 1'b0;

  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       string_done;
  logic       decode_error;

  int         fail_count;
  int         pending_count;

  // idle rates in percent; the stall rate is read by the receiver process,
  // so it is only ever updated with a nonblocking assignment
  int         send_idle_pct  = 8;
  int         recv_stall_pct = 57;
  int         chars_fed      = 0;
  int         quiet_cycles   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  base64url_stream_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .final_char   (final_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_byte    (data_byte),
    .byte_valid   (byte_valid),
    .string_done  (string_done),
    .decode_error (decode_error)
  );

  b64_decode_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_code     (char_code),
    .final_char    (final_char),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .data_byte     (data_byte),
    .byte_valid    (byte_valid),
    .string_done   (string_done),
    .decode_error  (decode_error),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Receiver: a fresh ready decision every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any beat on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sextet value to its character in the URL-safe alphabet.
  function automatic logic [7:0] alphabet_char(input int v);
    logic [7:0] ch;
    if (v < SEXTET_LOWER)       ch = CHAR_UPPER_A + 8'(v);
    else if (v < SEXTET_DIGIT)  ch = CHAR_LOWER_A + 8'(v - SEXTET_LOWER);
    else if (v < SEXTET_DASH)   ch = CHAR_DIGIT_0 + 8'(v - SEXTET_DIGIT);
    else if (v == SEXTET_DASH)  ch = CHAR_DASH;
    else                        ch = CHAR_USCORE;
    return ch;
  endfunction

  // One character beat. An idle gap may come first; valid then stays high
  // until the beat is taken, and without a gap the next call keeps it high.
  task automatic feed_char(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    char_code  <= ch;
    final_char <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_fed++;
  endtask

  // A whole string; the final flag goes on its last character.
  task automatic feed_string(input char_q_t s);
    foreach (s[i]) feed_char(s[i], i == s.size() - 1);
  endtask

  initial begin
    char_q_t s;
    int      kind;
    int      n;
    int      pos;
    int      rand_start;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed strings ----
    // full group: "Man"
    feed_string('{"T", "W", "F", "u"});
    // short group closed by two pads
    feed_string('{"A", "A", CHAR_PAD, CHAR_PAD});
    // top sextet values, output bytes FF FF BD
    feed_string('{CHAR_USCORE, CHAR_USCORE, CHAR_DASH, "9"});
    // lone character in the last group
    feed_string('{"A"});
    // data after padding
    feed_string('{"A", "B", CHAR_PAD, "C"});
    // foreign bytes at both extremes, error stays sticky
    feed_string('{8'h00, "a", 8'hFF});
    // nothing but padding is fine
    feed_string('{CHAR_PAD});
    // three characters, trailing bits dropped unchecked
    feed_string('{"a", "z", "0"});

    // ---- random strings ----
    // Most are well formed (optionally padded); the rest carry one corrupted
    // byte, a pad at a random place, a dangling character, or are pure noise.
    // Idle pattern: sender light / receiver heavy, then swapped, then none.
    rand_start = chars_fed;
    while (chars_fed - rand_start < RANDOM_CHARS) begin
      if (chars_fed - rand_start >= 2 * RANDOM_CHARS / 3) begin
        send_idle_pct   = 0;
        recv_stall_pct <= 0;
      end else if (chars_fed - rand_start >= RANDOM_CHARS / 3) begin
        send_idle_pct   = 57;
        recv_stall_pct <= 8;
      end
      s.delete();
      kind = $urandom_range(99);
      n    = $urandom_range(15);
      if (n % 4 == 1) n++;
      repeat (n) s.push_back(alphabet_char($urandom_range(63)));
      if (kind < 60) begin
        if ($urandom_range(1) == 1)
          while (s.size() % 4 != 0) s.push_back(CHAR_PAD);
      end else if (kind < 75) begin
        if (s.size() == 0) s.push_back(alphabet_char($urandom_range(63)));
        pos    = $urandom_range(s.size() - 1);
        s[pos] = 8'($urandom_range(255));
      end else if (kind < 85) begin
        s.insert($urandom_range(s.size()), CHAR_PAD);
      end else if (kind < 92) begin
        while (s.size() % 4 != 1) s.push_back(alphabet_char($urandom_range(63)));
      end else begin
        s.delete();
        repeat ($urandom_range(6, 1)) s.push_back(8'($urandom_range(255)));
      end
      // an empty string cannot be sent
      if (s.size() == 0) s.push_back(CHAR_PAD);
      feed_string(s);
    end

    // ---- drain ----
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
